FILE: src/smsd_pkg.sv
package smsd_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int IDX_W       = $clog2(MAX_WINDOW);
  localparam int LEN_W       = 7;
  localparam int MED_W       = SAMPLE_BITS + 1;
  localparam int TOTAL_W     = 32;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  // register index is paddr[2]
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic [LEN_W-1:0] WINDOW_LENGTH_RESET = 7'd8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MED,
    S_UPD,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   first_of_series;
  } in_t;

  typedef struct packed {
    logic               judged;
    logic               notify;
    logic [MED_W-1:0]   median_doubled;
    logic [TOTAL_W-1:0] notify_total;
  } out_t;

  typedef struct packed {
    logic                   upd;     // cells load their next value
    logic                   rm_en;   // drop one entry equal to x first
    logic [SAMPLE_BITS-1:0] x;
    logic [SAMPLE_BITS-1:0] s;
    logic [LEN_W-1:0]       n_ins;   // occupied entries seen by the insert
  } chain_ctl_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] wl);
    logic [LEN_W-1:0] res;
    if (wl == '0) begin
      res = LEN_W'(1);
    end else if (wl > LEN_W'(MAX_WINDOW)) begin
      res = LEN_W'(MAX_WINDOW);
    end else begin
      res = wl;
    end
    return res;
  endfunction

endpackage

FILE: src/smsd_cell.sv
module smsd_cell (
  input  logic                                  clk,
  input  smsd_pkg::chain_ctl_t                  ctl,
  input  logic [smsd_pkg::IDX_W-1:0]            idx,
  input  logic [smsd_pkg::SAMPLE_BITS-1:0]      left_w,
  input  logic                                  left_le,
  input  logic [smsd_pkg::SAMPLE_BITS-1:0]      right_v,
  output logic [smsd_pkg::SAMPLE_BITS-1:0]      v,
  output logic [smsd_pkg::SAMPLE_BITS-1:0]      w,
  output logic                                  le
);

  logic [smsd_pkg::SAMPLE_BITS-1:0] v_r;
  logic [smsd_pkg::SAMPLE_BITS-1:0] v_nxt;
  logic                             rm;

  // sorted order: every cell at or past the leaving value pulls from the right
  assign rm = ctl.rm_en && (v_r >= ctl.x);
  assign w  = rm ? right_v : v_r;
  assign le = ({1'b0, idx} < ctl.n_ins) && (w <= ctl.s);

  always_comb begin
    if (le) begin
      v_nxt = w;
    end else if (left_le) begin
      v_nxt = ctl.s;
    end else begin
      v_nxt = left_w;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      v_r <= v_nxt;
    end
  end

  assign v = v_r;

endmodule

FILE: src/smsd_chain.sv
module smsd_chain (
  input  logic                                  clk,
  input  smsd_pkg::chain_ctl_t                  ctl,
  input  logic [smsd_pkg::LEN_W-1:0]            len,
  output logic [smsd_pkg::MED_W-1:0]            med2
);

  localparam int N = smsd_pkg::MAX_WINDOW;

  logic [smsd_pkg::SAMPLE_BITS-1:0] v_a [N];
  logic [smsd_pkg::SAMPLE_BITS-1:0] w_a [N];
  logic                             le_a [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [smsd_pkg::SAMPLE_BITS-1:0] lw;
    logic                             lle;
    logic [smsd_pkg::SAMPLE_BITS-1:0] rv;

    if (i == 0) begin : g_head
      assign lw  = '0;
      assign lle = 1'b1;
    end else begin : g_body
      assign lw  = w_a[i-1];
      assign lle = le_a[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign rv = v_a[i];
    end else begin : g_mid
      assign rv = v_a[i+1];
    end

    smsd_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .idx     (smsd_pkg::IDX_W'(i)),
      .left_w  (lw),
      .left_le (lle),
      .right_v (rv),
      .v       (v_a[i]),
      .w       (w_a[i]),
      .le      (le_a[i])
    );
  end

  logic [smsd_pkg::IDX_W-1:0]       half;
  logic [smsd_pkg::IDX_W-1:0]       half_m1;
  logic [smsd_pkg::SAMPLE_BITS-1:0] mid_hi;
  logic [smsd_pkg::SAMPLE_BITS-1:0] mid_lo;

  // len of MAX_WINDOW gives half = MAX_WINDOW/2, which still fits IDX_W bits
  assign half    = smsd_pkg::IDX_W'(len >> 1);
  assign half_m1 = half - smsd_pkg::IDX_W'(1);
  assign mid_hi  = v_a[half];
  assign mid_lo  = v_a[half_m1];

  always_comb begin
    if (len[0]) begin
      med2 = {mid_hi, 1'b0};
    end else begin
      med2 = {1'b0, mid_lo} + {1'b0, mid_hi};
    end
  end

endmodule

FILE: src/smsd_hist.sv
module smsd_hist (
  input  logic                                  clk,
  input  logic                                  rd_en,
  input  logic [smsd_pkg::IDX_W-1:0]            rd_addr,
  output logic [smsd_pkg::SAMPLE_BITS-1:0]      rd_data,
  input  logic                                  wr_en,
  input  logic [smsd_pkg::IDX_W-1:0]            wr_addr,
  input  logic [smsd_pkg::SAMPLE_BITS-1:0]      wr_data
);

  logic [smsd_pkg::SAMPLE_BITS-1:0] mem [smsd_pkg::MAX_WINDOW];
  logic [smsd_pkg::SAMPLE_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/sliding_median_spike_detector.sv
// Sliding-median spike detector. Each item carries one unsigned sample; the
// block returns exactly one result per item. Once the window holds
// window_length samples, the sample is compared with twice the window median
// (sum of the two middle values for even lengths) and flagged when it is at
// least that large; the oldest sample then leaves and the new one takes its
// sorted place. The sorted window lives in a row of 64 cells, each comparing
// against its neighbors, all shifting together; the arrival-order copy is
// a 64-entry memory with a registered read. An item is accepted in the idle
// step together with the history read, and its result passes through the
// median select, cell update and output load steps to the output register;
// no new item is taken until that load is done, and a stalled output
// holds the block in its load step. Writing window_length clears the window
// but keeps the flag total; write it only while the block is idle.
module sliding_median_spike_detector (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  smsd_pkg::in_t                         in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output smsd_pkg::out_t                        out_data,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [smsd_pkg::ADDR_W-1:0]           paddr,
  input  logic [smsd_pkg::DATA_W-1:0]           pwdata,
  output logic [smsd_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready
);

  smsd_pkg::state_t                 state_r, state_nxt;
  logic [smsd_pkg::LEN_W-1:0]       wl_r;
  logic [smsd_pkg::LEN_W-1:0]       fill_r;
  logic [smsd_pkg::IDX_W-1:0]       ptr_r;
  logic [smsd_pkg::TOTAL_W-1:0]     total_r;
  logic [smsd_pkg::IDX_W-1:0]       p_r;
  logic [smsd_pkg::SAMPLE_BITS-1:0] sample_r;
  logic [smsd_pkg::MED_W-1:0]       med2_r;
  smsd_pkg::out_t                   res_r;
  smsd_pkg::out_t                   out_data_r;
  logic                             out_valid_r;

  logic [smsd_pkg::LEN_W-1:0]       len;
  logic                             in_acc;
  logic                             cfg_wr;
  logic                             full;
  logic                             notify;
  logic [smsd_pkg::TOTAL_W-1:0]     total_inc;
  logic [smsd_pkg::IDX_W-1:0]       ptr_eff;
  logic [smsd_pkg::IDX_W-1:0]       p_sel;
  logic [smsd_pkg::LEN_W-1:0]       p_next;
  logic [smsd_pkg::MED_W-1:0]       med2;
  logic [smsd_pkg::SAMPLE_BITS-1:0] hist_q;
  logic                             hist_we;
  logic [smsd_pkg::IDX_W-1:0]       hist_waddr;
  logic                             do_upd;
  logic                             do_load;
  logic                             out_free;
  smsd_pkg::chain_ctl_t             ctl;

  assign len      = smsd_pkg::eff_len(wl_r);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == smsd_pkg::REG_WINDOW_LENGTH);
  assign prdata   = (paddr[2] == smsd_pkg::REG_WINDOW_LENGTH) ?
                    smsd_pkg::DATA_W'(wl_r) : '0;
  assign out_free = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  assign ptr_eff   = in_data.first_of_series ? '0 : ptr_r;
  assign p_sel     = ({1'b0, ptr_eff} >= len) ? '0 : ptr_eff;
  assign full      = fill_r >= len;
  assign notify    = {1'b0, sample_r} >= med2_r;
  assign total_inc = (total_r == '1) ? total_r : total_r + smsd_pkg::TOTAL_W'(1);
  assign p_next    = {1'b0, p_r} + smsd_pkg::LEN_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      smsd_pkg::S_IDLE: if (in_valid) state_nxt = smsd_pkg::S_MED;
      smsd_pkg::S_MED:  state_nxt = smsd_pkg::S_UPD;
      smsd_pkg::S_UPD:  state_nxt = smsd_pkg::S_PUSH;
      smsd_pkg::S_PUSH: if (out_free) state_nxt = smsd_pkg::S_IDLE;
      default:          state_nxt = smsd_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    do_upd   = 1'b0;
    do_load  = 1'b0;
    unique case (state_r)
      smsd_pkg::S_IDLE: in_ready = 1'b1;
      smsd_pkg::S_MED:  ;
      smsd_pkg::S_UPD:  do_upd = 1'b1;
      smsd_pkg::S_PUSH: do_load = out_free;
      default:          ;
    endcase
  end

  always_comb begin
    ctl.upd   = do_upd;
    ctl.rm_en = full;
    ctl.x     = hist_q;
    ctl.s     = sample_r;
    ctl.n_ins = full ? len - smsd_pkg::LEN_W'(1) : fill_r;
  end

  assign hist_we    = do_upd;
  assign hist_waddr = full ? p_r : fill_r[smsd_pkg::IDX_W-1:0];

  smsd_chain u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .len  (len),
    .med2 (med2)
  );

  smsd_hist u_hist (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (p_sel),
    .rd_data (hist_q),
    .wr_en   (hist_we),
    .wr_addr (hist_waddr),
    .wr_data (sample_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smsd_pkg::S_IDLE;
      wl_r        <= smsd_pkg::WINDOW_LENGTH_RESET;
      fill_r      <= '0;
      ptr_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        wl_r   <= pwdata[smsd_pkg::LEN_W-1:0];
        fill_r <= '0;
        ptr_r  <= '0;
      end else if (in_acc && in_data.first_of_series) begin
        fill_r  <= '0;
        ptr_r   <= '0;
        total_r <= '0;
      end else if (do_upd) begin
        if (full) begin
          if (notify) total_r <= total_inc;
          ptr_r  <= (p_next >= len) ? '0 : p_next[smsd_pkg::IDX_W-1:0];
          fill_r <= len;
        end else begin
          ptr_r  <= '0;
          fill_r <= fill_r + smsd_pkg::LEN_W'(1);
        end
      end
      if (do_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_data.sample;
      p_r      <= p_sel;
    end
    if (state_r == smsd_pkg::S_MED) begin
      med2_r <= med2;
    end
    if (do_upd) begin
      if (full) begin
        res_r.judged         <= 1'b1;
        res_r.notify         <= notify;
        res_r.median_doubled <= med2_r;
        res_r.notify_total   <= notify ? total_inc : total_r;
      end else begin
        res_r.judged         <= 1'b0;
        res_r.notify         <= 1'b0;
        res_r.median_doubled <= '0;
        res_r.notify_total   <= total_r;
      end
    end
    if (do_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= len)
    else $error("fill count beyond window length");

  a_ptr_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, ptr_r} < len)
    else $error("oldest pointer beyond window length");

  a_upd_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == smsd_pkg::S_UPD) && !cfg_wr |=> (fill_r != '0))
    else $error("window empty after an item update");

  a_judged_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    do_upd && !full |=> !res_r.judged && (res_r.median_doubled == '0))
    else $error("judgement made on a window that was not full");

endmodule
